[rtl/integer_text_formatter_top_assert.svh]
// assertion macros for the integer text formatter top level
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef INTEGER_TEXT_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TEXT_FORMATTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ITF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itf assertion failed");
`define ITF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itf assertion failed");
`else
`define ITF_ASSERT_IMPL(label, ante, cons)
`define ITF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/itf_pkg.sv]
// shared types, widths and character codes of the integer text formatter
// no dependencies
package itf_pkg;

   localparam int VALUE_W   = 64;
   localparam int MAX_CHARS = 64;
   localparam int CNT_W     = $clog2(MAX_CHARS + 1);
   localparam int POS_W     = 8;
   localparam int NDIG_MAX  = 20;
   localparam int NDIG_W    = $clog2(NDIG_MAX + 1);
   localparam int DIG_W     = 4 * NDIG_MAX;
   localparam int STEP_W    = $clog2(VALUE_W);

   localparam logic [1:0] KIND_DEC  = 2'd0;
   localparam logic [1:0] KIND_LHEX = 2'd1;
   localparam logic [1:0] KIND_UHEX = 2'd2;
   localparam logic [1:0] KIND_PTR  = 2'd3;

   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_PLUS  = 2'd1;
   localparam logic [1:0] SIGN_MINUS = 2'd2;
   localparam logic [1:0] SIGN_SPACE = 2'd3;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LX    = 8'h78;
   localparam logic [7:0] CHAR_UX    = 8'h58;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_UA    = 8'h41;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  kind;
      logic        alt_form;
      logic [1:0]  sign_char;
      logic [6:0]  field_width;
      logic [5:0]  min_digits;
      logic        precision_given;
      logic        left_align;
      logic        zero_fill;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       no_char;
      logic       last;
      logic [6:0] char_count;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic [DIG_W-1:0]  digits;
      logic [NDIG_W-1:0] ndig;
   } conv_result_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      if (d < 4'd10) begin
         return CHAR_ZERO + {4'b0, d};
      end else begin
         return (upper ? CHAR_UA : CHAR_LA) + {4'b0, d} - 8'd10;
      end
   endfunction

endpackage

[rtl/itf_digit_conv.sv]
// bit-serial binary to digit converter: shift-add bcd for decimal, plain shift for hex
// then a nibble-serial pass that drops leading zero digits; uses itf_pkg
module itf_digit_conv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [itf_pkg::VALUE_W-1:0]   value,
   input  logic                          decimal,
   output itf_pkg::conv_result_type      result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_NORM = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [itf_pkg::VALUE_W-1:0]   val_ff, val_in;
   logic [itf_pkg::DIG_W-1:0]     bcd_ff, bcd_in;
   logic [itf_pkg::DIG_W-1:0]     adj;
   logic [itf_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [itf_pkg::NDIG_W-1:0]    ndig_ff, ndig_in;
   logic                          dec_ff, dec_in;
   logic                          shift_norm;

   always_comb begin
      for (int i = 0; i < itf_pkg::NDIG_MAX; i++) begin
         if (dec_ff && bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   assign shift_norm = (bcd_ff[itf_pkg::DIG_W-1 -: 4] == 4'd0) &&
                       (ndig_ff > itf_pkg::NDIG_W'(1));

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      ndig_in  = ndig_ff;
      dec_in   = dec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in   = value;
               dec_in   = decimal;
               bcd_in   = '0;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in  = {adj[itf_pkg::DIG_W-2:0], val_ff[itf_pkg::VALUE_W-1]};
            val_in  = {val_ff[itf_pkg::VALUE_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == itf_pkg::STEP_W'(itf_pkg::VALUE_W - 1)) begin
               ndig_in  = itf_pkg::NDIG_W'(itf_pkg::NDIG_MAX);
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (shift_norm) begin
               bcd_in  = {bcd_ff[itf_pkg::DIG_W-5:0], 4'd0};
               ndig_in = ndig_ff - 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff  <= val_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      ndig_ff <= ndig_in;
      dec_ff  <= dec_in;
   end

   assign result.done   = (state_ff == ST_NORM) && !shift_norm;
   assign result.digits = bcd_ff;
   assign result.ndig   = ndig_ff;

endmodule

[rtl/itf_emitter.sv]
// layout of the converted text and character-serial output with its beat register
// uses itf_pkg; digits arrive normalized from itf_digit_conv
module itf_emitter (
   input  logic                      clock,
   input  logic                      reset,
   input  itf_pkg::conv_result_type  conv,
   input  itf_pkg::req_type          fmt,
   output logic                      done,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output itf_pkg::rsp_type          rsp_payload
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SIZE  = 2'd1;
   localparam logic [1:0] ST_PLACE = 2'd2;
   localparam logic [1:0] ST_RUN   = 2'd3;

   localparam int PW = itf_pkg::POS_W;
   localparam int CW = itf_pkg::CNT_W;

   logic [1:0]                  state_ff, state_in;
   logic [itf_pkg::DIG_W-1:0]   dig_ff, dig_in;
   logic [itf_pkg::NDIG_W-1:0]  ndig_ff, ndig_in;
   logic [PW-1:0]               nd_ff, nd_in;
   logic [PW-1:0]               plen_ff, plen_in;
   logic [PW-1:0]               pz_ff, pz_in;
   logic [PW-1:0]               body_ff, body_in;
   logic [7:0]                  pre0_ff, pre0_in;
   logic [7:0]                  pre1_ff, pre1_in;
   logic                        upper_ff, upper_in;
   logic [PW-1:0]               b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic [PW-1:0]               b4_ff, b4_in, b5_ff, b5_in;
   logic [CW-1:0]               total_ff, total_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   itf_pkg::rsp_type            rsp_ff, rsp_in;

   logic [PW-1:0] prec, pad, lead, zpad, longest, width_x, pos;
   logic          nz, hexpre, zmode, load, fin;
   logic [7:0]    ch;

   always_comb begin
      prec    = fmt.precision_given ? {2'b0, fmt.min_digits} : '0;
      nz      = |fmt.value;
      hexpre  = (fmt.kind == itf_pkg::KIND_PTR) ||
                (fmt.alt_form && nz &&
                 (fmt.kind == itf_pkg::KIND_LHEX || fmt.kind == itf_pkg::KIND_UHEX));
      width_x = {1'b0, fmt.field_width};
      zmode   = !fmt.left_align && fmt.zero_fill && !fmt.precision_given;
      pad     = (width_x > body_ff) ? width_x - body_ff : '0;
      longest = (width_x > body_ff) ? width_x : body_ff;
      lead    = (!fmt.left_align && !zmode) ? pad : '0;
      zpad    = zmode ? pad : '0;
      pos     = PW'(idx_ff);
      fin     = (CW'(idx_ff + 1'b1) == total_ff);
      load    = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
      if (pos < b1_ff) begin
         ch = itf_pkg::CHAR_SPACE;
      end else if (pos < b2_ff) begin
         ch = (pos == b1_ff) ? pre0_ff : pre1_ff;
      end else if (pos < b4_ff) begin
         ch = itf_pkg::CHAR_ZERO;
      end else if (pos < b5_ff) begin
         ch = itf_pkg::digit_char(dig_ff[itf_pkg::DIG_W-1 -: 4], upper_ff);
      end else begin
         ch = itf_pkg::CHAR_SPACE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      ndig_in      = ndig_ff;
      nd_in        = nd_ff;
      plen_in      = plen_ff;
      pz_in        = pz_ff;
      body_in      = body_ff;
      pre0_in      = pre0_ff;
      pre1_in      = pre1_ff;
      upper_in     = upper_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      b5_in        = b5_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      done         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (conv.done) begin
               dig_in   = conv.digits;
               ndig_in  = conv.ndig;
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            if (fmt.precision_given && fmt.min_digits == 6'd0 && !nz) begin
               nd_in = '0;
            end else begin
               nd_in = PW'(ndig_ff);
            end
            upper_in = (fmt.kind == itf_pkg::KIND_UHEX);
            if (hexpre) begin
               plen_in = PW'(2);
               pre0_in = itf_pkg::CHAR_ZERO;
               pre1_in = (fmt.kind == itf_pkg::KIND_UHEX) ? itf_pkg::CHAR_UX
                                                         : itf_pkg::CHAR_LX;
            end else begin
               pre1_in = itf_pkg::CHAR_NUL;
               unique case (fmt.sign_char)
                  itf_pkg::SIGN_PLUS:  pre0_in = itf_pkg::CHAR_PLUS;
                  itf_pkg::SIGN_MINUS: pre0_in = itf_pkg::CHAR_MINUS;
                  itf_pkg::SIGN_SPACE: pre0_in = itf_pkg::CHAR_SPACE;
                  default:             pre0_in = itf_pkg::CHAR_NUL;
               endcase
               plen_in = (fmt.sign_char != itf_pkg::SIGN_NONE) ? PW'(1) : '0;
            end
            if (fmt.kind != itf_pkg::KIND_PTR && prec > nd_in) begin
               pz_in = prec - nd_in;
            end else begin
               pz_in = '0;
            end
            body_in  = plen_in + pz_in + nd_in;
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            b1_in    = lead;
            b2_in    = lead + plen_ff;
            b3_in    = b2_in + zpad;
            b4_in    = b3_in + pz_ff;
            b5_in    = b4_in + nd_ff;
            total_in = (longest > PW'(itf_pkg::MAX_CHARS)) ? CW'(itf_pkg::MAX_CHARS)
                                                          : CW'(longest);
            idx_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               if (total_ff == '0) begin
                  rsp_in.out_char   = itf_pkg::CHAR_NUL;
                  rsp_in.no_char    = 1'b1;
                  rsp_in.last       = 1'b1;
                  rsp_in.char_count = '0;
                  state_in          = ST_IDLE;
                  done              = 1'b1;
               end else begin
                  rsp_in.out_char   = ch;
                  rsp_in.no_char    = 1'b0;
                  rsp_in.last       = fin;
                  rsp_in.char_count = fin ? 7'(total_ff) : 7'd0;
                  idx_in            = idx_ff + 1'b1;
                  if (pos >= b4_ff && pos < b5_ff) begin
                     dig_in = {dig_ff[itf_pkg::DIG_W-5:0], 4'd0};
                  end
                  if (fin) begin
                     state_in = ST_IDLE;
                     done     = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dig_ff   <= dig_in;
      ndig_ff  <= ndig_in;
      nd_ff    <= nd_in;
      plen_ff  <= plen_in;
      pz_ff    <= pz_in;
      body_ff  <= body_in;
      pre0_ff  <= pre0_in;
      pre1_ff  <= pre1_in;
      upper_ff <= upper_in;
      b1_ff    <= b1_in;
      b2_ff    <= b2_in;
      b3_ff    <= b3_in;
      b4_ff    <= b4_in;
      b5_ff    <= b5_in;
      total_ff <= total_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/integer_text_formatter_top.sv]
// integer text formatter: printf-style integer conversion, one character per beat
// uses itf_pkg, itf_digit_conv, itf_emitter and integer_text_formatter_top_assert.svh
//
// req channel: one beat carries a 64-bit value and its format settings.
// rsp channel: one beat per output character; the last beat of a conversion has
// last set and the character count; an empty conversion gives one beat with
// no_char and last set.
// the value is shifted in one bit per cycle, leading zero digits are then
// dropped one digit per cycle, the emitter then takes the digits over, lays out
// the text in its sizing and placing states, and registers the first character.
// only one conversion is in flight at a time, and it gives at most 64 characters.
// req_ready is high while no conversion is in flight; the next request is taken
// while the last character still waits in the output register.
// a stalled receiver holds the output register and the character sequencer.
// reset is synchronous and returns the block to idle with no beat pending.
`include "integer_text_formatter_top_assert.svh"

module integer_text_formatter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itf_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itf_pkg::rsp_type  rsp_payload
);

   logic                      busy_ff, busy_in;
   itf_pkg::req_type          req_ff, req_in;
   itf_pkg::conv_result_type  conv;
   logic                      accept, emit_done;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      busy_in = busy_ff;
      req_in  = req_ff;
      if (accept) begin
         busy_in = 1'b1;
         req_in  = req_payload;
      end else if (emit_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      req_ff <= req_in;
   end

   itf_digit_conv u_conv (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .value   (req_payload.value),
      .decimal (req_payload.kind == itf_pkg::KIND_DEC),
      .result  (conv)
   );

   itf_emitter u_emit (
      .clock       (clock),
      .reset       (reset),
      .conv        (conv),
      .fmt         (req_ff),
      .done        (emit_done),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `ITF_ASSERT_IMPL(a_empty_is_last, rsp_valid && rsp_payload.no_char, rsp_payload.last)
   `ITF_ASSERT_IMPL(a_count_only_on_last, rsp_valid && !rsp_payload.last, rsp_payload.char_count == 7'd0)
   `ITF_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `ITF_ASSERT_IMPL(a_count_bound, rsp_valid && rsp_payload.last && !rsp_payload.no_char, rsp_payload.char_count != 7'd0 && rsp_payload.char_count <= 7'(itf_pkg::MAX_CHARS))

endmodule

[bench/itf_text_checker.sv]
`timescale 1ns / 1ps
// checker for the integer text formatter: predicts each conversion's characters
// and compares them beat by beat; uses itf_pkg types and character codes
module itf_text_checker
   import itf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      error_count,
   output int      pending,
   output int      conversions,
   output int      chars_checked,
   output int      empty_conversions
);

   rsp_type    expected_chars[$];
   rsp_type    want;
   logic [7:0] text_buf[MAX_CHARS];
   int         text_len;

   initial begin
      error_count = 0;
      pending = 0;
      conversions = 0;
      chars_checked = 0;
      empty_conversions = 0;
   end

   function automatic void add_chars(input int count, input logic [7:0] c);
      for (int i = 0; i < count && text_len < MAX_CHARS; i++) begin
         text_buf[text_len] = c;
         text_len++;
      end
   endfunction

   function automatic void format_text(input req_type item);
      logic [7:0]  digs[24];
      logic [63:0] v;
      logic [3:0]  d;
      logic [7:0]  pfx[2];
      logic        upper;
      int          base, ndig, prec, plen, pzeros, body, pad;
      rsp_type     beat;
      v = item.value;
      upper = (item.kind == KIND_UHEX);
      base = (item.kind == KIND_DEC) ? 10 : 16;
      prec = item.precision_given ? int'(item.min_digits) : 0;
      ndig = 0;
      plen = 0;
      text_len = 0;
      if (v == 64'd0) begin
         digs[0] = CHAR_ZERO;
         ndig = 1;
      end else begin
         while (v != 64'd0) begin
            d = 4'(v % base);
            digs[ndig] = (d < 4'd10) ? CHAR_ZERO + 8'(d) : (upper ? CHAR_UA : CHAR_LA) + 8'(d) - 8'd10;
            ndig++;
            v = v / base;
         end
      end
      // explicit zero precision on a zero value drops the lone digit
      if (item.precision_given && prec == 0 && item.value == 64'd0) ndig = 0;
      if (item.kind == KIND_PTR || (item.alt_form && item.value != 64'd0 &&
          (item.kind == KIND_LHEX || item.kind == KIND_UHEX))) begin
         pfx[0] = CHAR_ZERO;
         pfx[1] = upper ? CHAR_UX : CHAR_LX;
         plen = 2;
      end else if (item.sign_char != SIGN_NONE) begin
         case (item.sign_char)
            SIGN_PLUS:  pfx[0] = CHAR_PLUS;
            SIGN_MINUS: pfx[0] = CHAR_MINUS;
            default:    pfx[0] = CHAR_SPACE;
         endcase
         plen = 1;
      end
      pzeros = (item.kind != KIND_PTR && prec > ndig) ? prec - ndig : 0;
      body = plen + pzeros + ndig;
      pad = (int'(item.field_width) > body) ? int'(item.field_width) - body : 0;
      if (!item.left_align && !(item.zero_fill && !item.precision_given))
         add_chars(pad, CHAR_SPACE);
      for (int i = 0; i < plen; i++) add_chars(1, pfx[i]);
      if (!item.left_align && item.zero_fill && !item.precision_given)
         add_chars(pad, CHAR_ZERO);
      add_chars(pzeros, CHAR_ZERO);
      for (int i = ndig; i > 0; i--) add_chars(1, digs[i - 1]);
      if (item.left_align) add_chars(pad, CHAR_SPACE);
      if (text_len == 0) begin
         beat.out_char = CHAR_NUL;
         beat.no_char = 1'b1;
         beat.last = 1'b1;
         beat.char_count = 7'd0;
         expected_chars.push_back(beat);
         empty_conversions++;
      end else begin
         for (int i = 0; i < text_len; i++) begin
            beat.out_char = text_buf[i];
            beat.no_char = 1'b0;
            beat.last = (i + 1 == text_len);
            beat.char_count = (i + 1 == text_len) ? 7'(text_len) : 7'd0;
            expected_chars.push_back(beat);
         end
      end
   endfunction

   task automatic check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
               $display("%0t: character beat with nothing expected, expected none, got %h",
                        $time, rsp_payload);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               check_field("out_char", want.out_char, rsp_payload.out_char);
               check_field("no_char", 8'(want.no_char), 8'(rsp_payload.no_char));
               check_field("last", 8'(want.last), 8'(rsp_payload.last));
               check_field("char_count", 8'(want.char_count), 8'(rsp_payload.char_count));
            end
         end
         if (req_valid && req_ready) begin
            format_text(req_payload);
            conversions++;
         end
         pending = expected_chars.size();
      end
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// top of the integer text formatter bench: clock, reset, request and ready stimulus
// depends on itf_pkg, integer_text_formatter_top and itf_text_checker
module tb_top;
   import itf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 248;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    idle_on;
   int      error_count, pending, conversions, chars_checked, empty_conversions;
   int      quiet_cycles;

   integer_text_formatter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   itf_text_checker text_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .error_count       (error_count),
      .pending           (pending),
      .conversions       (conversions),
      .chars_checked     (chars_checked),
      .empty_conversions (empty_conversions)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      idle_on = 1'b1;
      quiet_cycles = 0;
   end

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= !(idle_on && $urandom_range(99) < 22);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb_top: watchdog expired with %0d characters outstanding", pending);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic [63:0] v, input logic [1:0] k,
                                        input logic alt, input logic [1:0] s,
                                        input int w, input int p, input logic dot,
                                        input logic left, input logic zf);
      req_type r;
      r.value = v;
      r.kind = k;
      r.alt_form = alt;
      r.sign_char = s;
      r.field_width = 7'(w);
      r.min_digits = 6'(p);
      r.precision_given = dot;
      r.left_align = left;
      r.zero_fill = zf;
      return r;
   endfunction

   function automatic logic [63:0] rand_value();
      case ($urandom_range(5))
         0:       return 64'd0;
         1:       return '1;
         2:       return 64'($urandom_range(15));
         3:       return {$urandom, $urandom} >> $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type rand_req();
      return make_req(rand_value(), 2'($urandom_range(3)), 1'($urandom_range(1)),
                      2'($urandom_range(3)),
                      ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(24),
                      ($urandom_range(3) == 0) ? $urandom_range(62) : $urandom_range(24),
                      1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
   endfunction

   task automatic send_request(input req_type item);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_output();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      req_type directed[$];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_req(64'd0, KIND_DEC, 0, SIGN_NONE, 0, 0, 0, 0, 0));
      directed.push_back(make_req(64'd0, KIND_DEC, 0, SIGN_NONE, 0, 0, 1, 0, 0));
      directed.push_back(make_req(64'd0, KIND_PTR, 0, SIGN_NONE, 0, 0, 1, 0, 0));
      directed.push_back(make_req(64'd0, KIND_PTR, 0, SIGN_PLUS, 0, 0, 0, 0, 0));
      directed.push_back(make_req('1, KIND_DEC, 0, SIGN_NONE, 0, 0, 0, 0, 0));
      directed.push_back(make_req('1, KIND_LHEX, 1, SIGN_NONE, 0, 0, 0, 0, 0));
      directed.push_back(make_req('1, KIND_UHEX, 1, SIGN_SPACE, 0, 0, 0, 0, 0));
      directed.push_back(make_req(64'hABC, KIND_UHEX, 0, SIGN_PLUS, 0, 0, 0, 0, 0));
      directed.push_back(make_req(64'd1234, KIND_DEC, 0, SIGN_MINUS, 8, 0, 0, 0, 0));
      directed.push_back(make_req(64'd7, KIND_DEC, 0, SIGN_SPACE, 0, 3, 1, 0, 0));
      directed.push_back(make_req(64'd0, KIND_LHEX, 1, SIGN_PLUS, 4, 0, 0, 0, 0));
      directed.push_back(make_req(64'hDEAD, KIND_PTR, 0, SIGN_MINUS, 0, 10, 1, 0, 0));
      directed.push_back(make_req(64'd99, KIND_DEC, 0, SIGN_PLUS, 20, 0, 0, 0, 1));
      directed.push_back(make_req(64'd99, KIND_DEC, 0, SIGN_PLUS, 20, 5, 1, 0, 1));
      directed.push_back(make_req(64'h5A, KIND_LHEX, 1, SIGN_NONE, 12, 0, 0, 1, 1));
      directed.push_back(make_req(64'd3, KIND_DEC, 0, SIGN_NONE, 64, 0, 0, 0, 0));
      directed.push_back(make_req(64'd3, KIND_DEC, 0, SIGN_MINUS, 64, 0, 0, 1, 0));
      directed.push_back(make_req(64'h1, KIND_UHEX, 1, SIGN_NONE, 0, 62, 1, 0, 0));
      directed.push_back(make_req(64'd42, KIND_DEC, 0, SIGN_PLUS, 64, 62, 1, 0, 0));
      directed.push_back(make_req(64'hBEEF, KIND_PTR, 0, SIGN_NONE, 30, 0, 0, 0, 1));
      directed.push_back(make_req(64'd0, KIND_DEC, 0, SIGN_NONE, 5, 0, 1, 0, 0));
      directed.push_back(make_req(64'd0, KIND_UHEX, 1, SIGN_PLUS, 3, 0, 1, 1, 0));
      directed.push_back(make_req(64'd42, KIND_DEC, 0, SIGN_NONE, 0, 45, 0, 0, 0));
      directed.push_back(make_req(64'h8000_0000_0000_0000, KIND_LHEX, 0, SIGN_MINUS,
                                  63, 33, 1, 1, 1));
      foreach (directed[i]) send_request(directed[i]);
      drain_output();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = !(n >= 100 && n < 160);
         if (n == 200) drain_output();
         send_request(rand_req());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(posedge clock);

      $display("tb_top: %0d conversions, %0d character beats, %0d empty conversions",
               conversions, chars_checked, empty_conversions);
      $display("tb_top: all kinds, signs, fill, alignment, precision and widths to 64 seen");
      if (error_count == 0 && pending == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
